### rtl/scld_pkg.sv
`default_nettype none

package scld_pkg;

    localparam int LEN_W = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] MAKE_MAX    = 8'd58;
    localparam logic [6:0] KEY_BKSP    = 7'h0E;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] KEY_CTRL    = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_ALT     = 7'h38;
    localparam logic [6:0] KEY_ENTER   = 7'h1C;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_EOL   = 2'd3;

    typedef enum logic [1:0] {
        OP_ECHO  = 2'd0,
        OP_ERASE = 2'd1,
        OP_LINE  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic             dropped;
        logic             ctrl;
        logic             alt;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // Lower-case key map; letters are shifted to upper case when asked.
    function automatic logic [7:0] char_lookup(input logic [5:0] code, input logic upper);
        logic [7:0] c;
        begin
            case (code)
                6'h02: c = "1";
                6'h03: c = "2";
                6'h04: c = "3";
                6'h05: c = "4";
                6'h06: c = "5";
                6'h07: c = "6";
                6'h08: c = "7";
                6'h09: c = "8";
                6'h0A: c = "9";
                6'h0B: c = "0";
                6'h0C: c = "-";
                6'h0D: c = "=";
                6'h10: c = "q";
                6'h11: c = "w";
                6'h12: c = "e";
                6'h13: c = "r";
                6'h14: c = "t";
                6'h15: c = "y";
                6'h16: c = "u";
                6'h17: c = "i";
                6'h18: c = "o";
                6'h19: c = "p";
                6'h1A: c = "[";
                6'h1B: c = "]";
                6'h1E: c = "a";
                6'h1F: c = "s";
                6'h20: c = "d";
                6'h21: c = "f";
                6'h22: c = "g";
                6'h23: c = "h";
                6'h24: c = "j";
                6'h25: c = "k";
                6'h26: c = "l";
                6'h27: c = ";";
                6'h28: c = 8'h27;
                6'h29: c = 8'h60;
                6'h2B: c = 8'h5C;
                6'h2C: c = "z";
                6'h2D: c = "x";
                6'h2E: c = "c";
                6'h2F: c = "v";
                6'h30: c = "b";
                6'h31: c = "n";
                6'h32: c = "m";
                6'h33: c = ",";
                6'h34: c = ".";
                6'h35: c = "/";
                6'h39: c = " ";
                default: c = "?";
            endcase
            if (upper && (c >= "a") && (c <= "z"))
            begin
                c = c - 8'd32;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/scld_ram.sv
`default_nettype none

module scld_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 63,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/scld_queue.sv
`default_nettype none

module scld_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire scld_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output scld_pkg::cmd_t     head,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = $clog2(scld_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(scld_pkg::QUEUE_DEPTH + 1);

    scld_pkg::cmd_t   entries [0:scld_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(scld_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(scld_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(scld_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/scld_front.sv
`default_nettype none

module scld_front #(
    parameter int LINE_CHARS = 63
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] scancode,
    output logic            push,
    output scld_pkg::cmd_t  push_cmd
);

    logic                       caps_reg, caps_next;
    logic                       ctrl_reg, ctrl_next;
    logic                       alt_reg, alt_next;
    logic [scld_pkg::LEN_W-1:0] len_reg, len_next;
    logic [6:0]                 code;
    logic [7:0]                 mapped;

    assign code   = scancode[6:0];
    assign mapped = scld_pkg::char_lookup(scancode[5:0], caps_reg);

    always_comb
    begin
        caps_next        = caps_reg;
        ctrl_next        = ctrl_reg;
        alt_next         = alt_reg;
        len_next         = len_reg;
        push             = 1'b0;
        push_cmd.op      = scld_pkg::OP_ECHO;
        push_cmd.ch      = mapped;
        push_cmd.dropped = 1'b0;
        push_cmd.ctrl    = ctrl_reg;
        push_cmd.alt     = alt_reg;
        push_cmd.len     = len_reg;
        if (accept)
        begin
            if ((scancode & scld_pkg::RELEASE_BIT) != 8'h00)
            begin
                if (code == scld_pkg::KEY_CTRL)
                begin
                    ctrl_next = 1'b0;
                end
                if (code == scld_pkg::KEY_LSHIFT)
                begin
                    caps_next = 1'b0;
                end
                if (code == scld_pkg::KEY_ALT)
                begin
                    alt_next = 1'b0;
                end
            end
            else if (scancode <= scld_pkg::MAKE_MAX)
            begin
                if (code == scld_pkg::KEY_BKSP)
                begin
                    if (len_reg != '0)
                    begin
                        len_next    = len_reg - scld_pkg::LEN_W'(1);
                        push        = 1'b1;
                        push_cmd.op = scld_pkg::OP_ERASE;
                    end
                end
                else if (code == scld_pkg::KEY_ENTER)
                begin
                    len_next    = '0;
                    push        = 1'b1;
                    push_cmd.op = scld_pkg::OP_LINE;
                end
                else if (code == scld_pkg::KEY_CAPS)
                begin
                    caps_next = !caps_reg;
                end
                else if (code == scld_pkg::KEY_LSHIFT)
                begin
                    caps_next = 1'b1;
                end
                else if (code == scld_pkg::KEY_CTRL)
                begin
                    ctrl_next = 1'b1;
                end
                else if (code == scld_pkg::KEY_ALT)
                begin
                    alt_next = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                    if (len_reg < scld_pkg::LEN_W'(LINE_CHARS))
                    begin
                        len_next = len_reg + scld_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        push_cmd.dropped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg <= 1'b0;
            ctrl_reg <= 1'b0;
            alt_reg  <= 1'b0;
            len_reg  <= '0;
        end
        else
        begin
            caps_reg <= caps_next;
            ctrl_reg <= ctrl_next;
            alt_reg  <= alt_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

### rtl/scld_back.sv
`default_nettype none

module scld_back #(
    parameter int LINE_CHARS = 63
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire scld_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         ch,
    output logic               dropped,
    output logic               ctrl_down,
    output logic               alt_down,
    output logic               last
);

    localparam int ADDR_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EOL  = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [scld_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [scld_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       lctrl_reg, lctrl_next;
    logic                       lalt_reg, lalt_next;
    logic                       valid_reg, valid_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [7:0]                 ch_reg, ch_next;
    logic                       dropped_reg, dropped_next;
    logic                       ctrl_reg, ctrl_next;
    logic                       alt_reg, alt_next;
    logic                       last_reg, last_next;
    logic                       out_free;
    logic                       wr_en;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [7:0]                 rd_data;
    logic [scld_pkg::LEN_W-1:0] idx_inc;

    assign out_free = !valid_reg || !out_stall;
    assign idx_inc  = idx_reg + scld_pkg::LEN_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        lctrl_next   = lctrl_reg;
        lalt_next    = lalt_reg;
        valid_next   = valid_reg && out_stall;
        kind_next    = kind_reg;
        ch_next      = ch_reg;
        dropped_next = dropped_reg;
        ctrl_next    = ctrl_reg;
        alt_next     = alt_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop          = 1'b1;
                    ctrl_next    = head.ctrl;
                    alt_next     = head.alt;
                    dropped_next = 1'b0;
                    ch_next      = 8'h00;
                    last_next    = 1'b1;
                    case (head.op)
                        scld_pkg::OP_ECHO:
                        begin
                            valid_next   = 1'b1;
                            kind_next    = scld_pkg::KIND_ECHO;
                            ch_next      = head.ch;
                            dropped_next = head.dropped;
                            wr_en        = !head.dropped;
                        end
                        scld_pkg::OP_ERASE:
                        begin
                            valid_next = 1'b1;
                            kind_next  = scld_pkg::KIND_ERASE;
                        end
                        scld_pkg::OP_LINE:
                        begin
                            if (head.len == '0)
                            begin
                                valid_next = 1'b1;
                                kind_next  = scld_pkg::KIND_EOL;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = '0;
                                len_next   = head.len;
                                lctrl_next = head.ctrl;
                                lalt_next  = head.alt;
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    valid_next   = 1'b1;
                    kind_next    = scld_pkg::KIND_CHAR;
                    ch_next      = rd_data;
                    dropped_next = 1'b0;
                    ctrl_next    = lctrl_reg;
                    alt_next     = lalt_reg;
                    last_next    = 1'b0;
                    if (idx_inc < len_reg)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[ADDR_W-1:0];
                        idx_next = idx_inc;
                    end
                    else
                    begin
                        state_next = ST_EOL;
                    end
                end
            end
            ST_EOL:
            begin
                if (out_free)
                begin
                    valid_next   = 1'b1;
                    kind_next    = scld_pkg::KIND_EOL;
                    ch_next      = 8'h00;
                    dropped_next = 1'b0;
                    ctrl_next    = lctrl_reg;
                    alt_next     = lalt_reg;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    scld_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CHARS),
        .ADDR_W(ADDR_W)
    ) u_line_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(head.len[ADDR_W-1:0]),
        .wr_data(head.ch),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        lctrl_reg   <= lctrl_next;
        lalt_reg    <= lalt_next;
        kind_reg    <= kind_next;
        ch_reg      <= ch_next;
        dropped_reg <= dropped_next;
        ctrl_reg    <= ctrl_next;
        alt_reg     <= alt_next;
        last_reg    <= last_next;
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign ch        = ch_reg;
    assign dropped   = dropped_reg;
    assign ctrl_down = ctrl_reg;
    assign alt_down  = alt_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### rtl/scancode_line_decoder.sv
// Line editor driven by set-1 keyboard scancodes.
// Input channel: one scancode byte per item on scancode, with in_valid and
// in_stall. Output channel: one result per item on kind, ch, dropped,
// ctrl_down, alt_down and last, with out_valid and out_stall.
// The front decodes each scancode in the cycle it is accepted, updates the
// modifier flags and the line length, and posts a command to a four-entry
// queue; modifier keys, releases and ignored codes post nothing.
// The back executes commands in order and owns the line memory.
// An echo or erase result passes through the queue and the result register.
// Enter on a line of N characters gives N + 1 results: when N > 0 the back
// first reads the memory's registered read port, then gives the characters
// one per cycle while out_stall is low, and last the end-of-line result.
// The input takes one scancode per cycle until the queue is full.
// When the receiver stalls, the result register holds its value and the
// queue fills; in_stall rises once four commands wait.
// Reset clears the flags, the line length, the queue and the output valid.
`default_nettype none

module scancode_line_decoder #(
    parameter int LINE_CHARS = 63
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] scancode,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      ch,
    output logic            dropped,
    output logic            ctrl_down,
    output logic            alt_down,
    output logic            last
);

    scld_pkg::cmd_t push_cmd;
    scld_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic           accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    scld_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .scancode(scancode),
        .push    (push),
        .push_cmd(push_cmd)
    );

    scld_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    scld_back #(
        .LINE_CHARS(LINE_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .ch       (ch),
        .dropped  (dropped),
        .ctrl_down(ctrl_down),
        .alt_down (alt_down),
        .last     (last)
    );

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("line stream broke before its end-of-line result");

    a_mid_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == scld_pkg::KIND_CHAR)
        else $error("a result other than a line character is not final");

    a_drop_on_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> kind == scld_pkg::KIND_ECHO && last)
        else $error("drop mark on a result that is not an echo");

    a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == scld_pkg::KIND_ERASE || kind == scld_pkg::KIND_EOL)
        |-> ch == 8'h00)
        else $error("erase or end-of-line result carries a character");

endmodule

`default_nettype wire
